// ===== design/salc_pkg.sv =====
`default_nettype none

package salc_pkg;

	localparam int unsigned WAYS_DEF     = 8;
	localparam int unsigned MAX_SETS_DEF = 64;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned TAG_W      = 32;
	localparam int unsigned STAMP_W    = 32;
	localparam int unsigned OFFSET_W   = 5;
	localparam int unsigned SETBITS_W  = 3;
	localparam int unsigned WAY_OUT_W  = 3;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 5;

	// Widest set field before folding onto the implemented sets (mask of 2^7 - 1).
	localparam int unsigned RAW_SET_W = (1 << SETBITS_W) - 1;
	// Shift amount for the tag: offset bits plus set bits.
	localparam int unsigned TAG_SHIFT_W = OFFSET_W + 1;

	localparam logic [OFFSET_W-1:0]  OFFSET_BITS_RST = OFFSET_W'(5);
	localparam logic [SETBITS_W-1:0] SET_BITS_RST    = SETBITS_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS = 1'b0,
		CFG_SET_BITS    = 1'b1
	} cfg_reg_t;

	// One way of one set in the tag store.
	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} way_entry_t;

endpackage

`default_nettype wire

// ===== design/salc_ram.sv =====
`default_nettype none

module salc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the contents before a write to the same address in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/salc_addr_split.sv =====
`default_nettype none

module salc_addr_split #(
	parameter int unsigned MAX_SETS = salc_pkg::MAX_SETS_DEF,
	parameter int unsigned SET_W    = 6
) (
	input  logic [salc_pkg::ADDR_W-1:0]    address,
	input  logic [salc_pkg::OFFSET_W-1:0]  offset_bits,
	input  logic [salc_pkg::SETBITS_W-1:0] set_bits,
	output logic [SET_W-1:0]               set_idx,
	output logic [salc_pkg::TAG_W-1:0]     tag
);

	import salc_pkg::*;

	localparam int unsigned TBL_DEPTH = 1 << RAW_SET_W;

	logic [ADDR_W-1:0]      shifted;
	logic [RAW_SET_W-1:0]   set_mask;
	logic [RAW_SET_W-1:0]   raw_set;
	logic [TAG_SHIFT_W-1:0] tag_shift;
	logic [SET_W-1:0]       fold_tbl [TBL_DEPTH];

	// Folds the masked set field onto the implemented sets, so larger set counts alias.
	for (genvar gi = 0; gi < TBL_DEPTH; gi++) begin : g_fold
		assign fold_tbl[gi] = SET_W'(gi % MAX_SETS);
	end

	assign shifted   = address >> offset_bits;
	assign set_mask  = RAW_SET_W'((8'd1 << set_bits) - 8'd1);
	assign raw_set   = RAW_SET_W'(shifted) & set_mask;
	assign set_idx   = fold_tbl[raw_set];
	assign tag_shift = {1'b0, offset_bits} + {{(TAG_SHIFT_W - SETBITS_W){1'b0}}, set_bits};
	// A shift of the full width or more leaves a zero tag.
	assign tag       = address >> tag_shift;

endmodule

`default_nettype wire

// ===== design/salc_way_select.sv =====
`default_nettype none

module salc_way_select #(
	parameter int unsigned WAYS  = salc_pkg::WAYS_DEF,
	parameter int unsigned WAY_W = 3
) (
	input  salc_pkg::way_entry_t [WAYS-1:0] row,
	input  logic [salc_pkg::TAG_W-1:0]      tag,
	input  logic [salc_pkg::STAMP_W-1:0]    stamp,
	output logic                            hit,
	output logic [WAY_W-1:0]                way,
	output salc_pkg::way_entry_t [WAYS-1:0] new_row
);

	import salc_pkg::*;

	// Leaves of the victim tree, padded to a power of two.
	localparam int unsigned LEAVES = 1 << $clog2(WAYS);

	logic               ok_n [2*LEAVES];
	logic [STAMP_W-1:0] st_n [2*LEAVES];
	logic [WAY_W-1:0]   ix_n [2*LEAVES];
	logic [WAY_W-1:0]   hit_way;
	logic [WAY_W-1:0]   victim;

	// Lowest matching valid way wins.
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row[w].valid && row[w].tag == tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	// Minimum tree over stamps strictly below the current stamp. On equal stamps the
	// left (lower) way is kept, which matches a first-found linear scan.
	always_comb begin
		for (int n = 0; n < LEAVES; n++) begin
			ok_n[n] = 1'b0;
			st_n[n] = '0;
			ix_n[n] = '0;
		end
		for (int i = 0; i < LEAVES; i++) begin
			if (i < WAYS) begin
				ok_n[LEAVES + i] = row[i].stamp < stamp;
				st_n[LEAVES + i] = row[i].stamp;
			end else begin
				ok_n[LEAVES + i] = 1'b0;
				st_n[LEAVES + i] = '0;
			end
			ix_n[LEAVES + i] = WAY_W'(i);
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			if (ok_n[2*n+1] && (!ok_n[2*n] || st_n[2*n+1] < st_n[2*n])) begin
				ok_n[n] = ok_n[2*n+1];
				st_n[n] = st_n[2*n+1];
				ix_n[n] = ix_n[2*n+1];
			end else begin
				ok_n[n] = ok_n[2*n];
				st_n[n] = st_n[2*n];
				ix_n[n] = ix_n[2*n];
			end
		end
		victim = ok_n[1] ? ix_n[1] : '0;
	end

	always_comb begin
		new_row = row;
		if (hit) begin
			new_row[hit_way].stamp = stamp;
		end else begin
			new_row[victim].valid = 1'b1;
			new_row[victim].tag   = tag;
			new_row[victim].stamp = stamp;
		end
	end

	assign way = hit ? hit_way : victim;

endmodule

`default_nettype wire

// ===== design/set_assoc_lru_cache_lookup_unit.sv =====
// Tag-only lookup for a set-associative cache with least-recently-used replacement
// (eight ways by default). Each request carries one byte address; the block splits it
// by the configured offset and set-index widths, compares all ways of the set in
// parallel, and returns whether the tag hit and which way was hit or refilled. The
// unit takes one request per clock unless a stalled response backs up the pipeline. The
// set row is read from the single-port-per-direction tag RAM on acceptance; the lookup
// stage compares, picks the victim and writes the row back as the result is registered.
// A request to the same set right behind another is served from a bypass register, so
// back-to-back accesses to one set need no stall. After reset the block clears the
// tag RAM, one set per cycle, and holds req_stall high meanwhile;
// configuration writes are taken at any time but must only be issued while idle.
`default_nettype none

module set_assoc_lru_cache_lookup_unit #(
	parameter int unsigned WAYS     = salc_pkg::WAYS_DEF,
	parameter int unsigned MAX_SETS = salc_pkg::MAX_SETS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Request channel.
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [salc_pkg::ADDR_W-1:0]      address,
	// Response channel.
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic                             hit,
	output logic [salc_pkg::WAY_OUT_W-1:0]   way_used,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import salc_pkg::*;

	localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned ROW_W = WAYS * $bits(way_entry_t);

	typedef way_entry_t [WAYS-1:0] row_t;

	// Configuration registers.
	logic [OFFSET_W-1:0]  offset_bits_q;
	logic [SETBITS_W-1:0] set_bits_q;

	// Access stamp, bumped once per accepted request.
	logic [STAMP_W-1:0] stamp_q;
	logic [STAMP_W-1:0] stamp_next;

	// Clearing pass after reset.
	logic             clr_busy_q;
	logic [SET_W-1:0] clr_addr_q;

	// Lookup stage: the RAM row arrives here.
	logic             valid_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [STAMP_W-1:0] stamp_s1;
	logic             fwd_s1;
	row_t             fwd_row_s1;

	// Result register.
	logic                 valid_s2;
	logic                 hit_s2;
	logic [WAY_OUT_W-1:0] way_s2;

	logic             accept;
	logic             s2_free;
	logic             retire;
	logic [SET_W-1:0] set_idx;
	logic [TAG_W-1:0] tag;
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] ram_wdata;
	logic [SET_W-1:0] ram_waddr;
	logic             ram_we;
	row_t             row_cur;
	row_t             row_new;
	logic             sel_hit;
	logic [WAY_W-1:0] sel_way;

	// Handshake. The result register frees when empty or when its result is taken;
	// the lookup stage retires into it then, and a new request can enter behind.
	assign s2_free   = !valid_s2 || !rsp_stall;
	assign retire    = valid_s1 && s2_free;
	assign req_stall = clr_busy_q || (valid_s1 && !s2_free);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	assign stamp_next = stamp_q + STAMP_W'(1);

	salc_addr_split #(
		.MAX_SETS (MAX_SETS),
		.SET_W    (SET_W)
	) u_split (
		.address     (address),
		.offset_bits (offset_bits_q),
		.set_bits    (set_bits_q),
		.set_idx     (set_idx),
		.tag         (tag)
	);

	// The clearing pass owns the write port until it ends; no request is in flight then.
	assign ram_we    = clr_busy_q || retire;
	assign ram_waddr = clr_busy_q ? clr_addr_q : set_s1;
	assign ram_wdata = clr_busy_q ? '0 : ROW_W'(row_new);

	salc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_SETS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (set_idx),
		.rdata (ram_rdata)
	);

	// The RAM read misses a write to the same set at the same edge, so that row comes
	// from the bypass register instead.
	assign row_cur = fwd_s1 ? fwd_row_s1 : row_t'(ram_rdata);

	salc_way_select #(
		.WAYS  (WAYS),
		.WAY_W (WAY_W)
	) u_select (
		.row     (row_cur),
		.tag     (tag_s1),
		.stamp   (stamp_s1),
		.hit     (sel_hit),
		.way     (sel_way),
		.new_row (row_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFFSET_BITS_RST;
			set_bits_q    <= SET_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data[OFFSET_W-1:0];
				CFG_SET_BITS:    set_bits_q    <= cfg_data[SETBITS_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == SET_W'(MAX_SETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + SET_W'(1);
		end
	end

	// Lookup stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q  <= '0;
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			stamp_q  <= stamp_next;
			valid_s1 <= 1'b1;
			fwd_s1   <= retire && (set_s1 == set_idx);
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Lookup stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1     <= set_idx;
			tag_s1     <= tag;
			stamp_s1   <= stamp_next;
			fwd_row_s1 <= row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			hit_s2 <= sel_hit;
			way_s2 <= WAY_OUT_W'(sel_way);
		end
	end

	assign rsp_valid = valid_s2;
	assign hit       = hit_s2;
	assign way_used  = way_s2;

endmodule

`default_nettype wire

// ===== design/salc_checker.sv =====
`default_nettype none

module salc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_stall,
	input logic                             rsp_valid,
	input logic                             rsp_stall,
	input logic                             hit,
	input logic [salc_pkg::WAY_OUT_W-1:0]   way_used
);

	// A stalled response keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(hit) && $stable(way_used))
		else $error("response changed while stalled");

	// Every accepted request is followed by a response.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |-> ##2 rsp_valid)
		else $error("accepted request produced no response");

	// A new response comes only from an earlier accepted request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("response appeared without a request");

	// Once the clearing pass is over, an empty response side never stalls requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid && !$past(req_stall) |-> !req_stall)
		else $error("requests stalled with no pending response");

endmodule

bind set_assoc_lru_cache_lookup_unit salc_checker u_salc_checker (.*);

`default_nettype wire
